### design/ght_pkg.sv
// shared types and constants for the generational handle table
// no dependencies
`timescale 1ns / 1ps

package ght_pkg;

    // live marks are kept in rows of this many bits
    localparam int ROW_W  = 32;
    localparam int ROW_BW = 5;

    typedef enum logic [1:0] {
        ACT_ALLOC  = 2'd0,
        ACT_LOOKUP = 2'd1,
        ACT_FREE   = 2'd2,
        ACT_CLEAR  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_INVALID = 2'd2
    } t_status;

    // which result the output register takes
    typedef enum logic [2:0] {
        O_NONE   = 3'd0,
        O_LOOKUP = 3'd1,
        O_ALLOC  = 3'd2,
        O_FULL   = 3'd3,
        O_CLEAR  = 3'd4
    } t_out_sel;

    // table write operations
    typedef enum logic [2:0] {
        W_NONE  = 3'd0,
        W_INIT  = 3'd1,
        W_ALLOC = 3'd2,
        W_FREE  = 3'd3,
        W_CLR   = 3'd4
    } t_wr_op;

    // slot index register operations
    typedef enum logic [1:0] {
        X_HOLD = 2'd0,
        X_REQ  = 2'd1,
        X_ZERO = 2'd2,
        X_INC  = 2'd3
    } t_x_op;

    typedef struct packed {
        logic     cap;
        t_x_op    x_op;
        t_wr_op   wr_op;
        t_out_sel out_sel;
        logic     rd_hint;
        logic     hint_inc;
        logic     hint_clr;
    } t_cmd;

    typedef struct packed {
        t_action action;
        logic    out_free;
        logic    hit;
        logic    row_free;
        logic    hint_full;
        logic    idx_last;
    } t_sts;

endpackage

### design/generational_handle_table_core.sv
// top level of the generational handle table
// depends on ght_pkg, ght_ctrl and ght_dp
`timescale 1ns / 1ps

// generational handle table: SLOTS entries, each with a live mark, a 32-bit
// generation, a 64-bit payload word and a 16-bit stage tag. one request at a
// time; the result sits in an output register so the next request is taken
// while it waits. lookup and free make one registered memory read, then the
// check and write back. allocate reads the hint row, picks the lowest free
// bit, then reads the generation for the reply; every fully used row of 32
// slots that the search walks past adds another row read and check. once the
// search has walked past the last row a full table answers. a hint register
// remembers the lowest row that can still hold a free slot, so rows below it
// are never rescanned. clear all sweeps the table through the single
// generation memory port, a read and then a write for every slot. after reset
// a clearing pass zeroes every generation and live mark with ready low. the
// caller owns the objects the payload words stand for; nothing here releases
// them.

module generational_handle_table_core
    import ght_pkg::*;
#(
    parameter int SLOTS = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_handle_slot,
    input  logic [31:0] i_handle_generation,
    input  logic [63:0] i_payload,
    input  logic [15:0] i_stage_tag,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [31:0] o_out_slot,
    output logic [31:0] o_out_generation,
    output logic [63:0] o_out_payload,
    output logic [15:0] o_out_stage
);

    // command and status between sequencer and datapath
    t_cmd w_cmd;
    t_sts w_sts;

    ght_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // memories, free-slot search and the output register live here
    ght_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_sts               (w_sts),
        .i_action            (i_action),
        .i_handle_slot       (i_handle_slot),
        .i_handle_generation (i_handle_generation),
        .i_payload           (i_payload),
        .i_stage_tag         (i_stage_tag),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_status            (o_status),
        .o_out_slot          (o_out_slot),
        .o_out_generation    (o_out_generation),
        .o_out_payload       (o_out_payload),
        .o_out_stage         (o_out_stage)
    );

endmodule

### design/ght_ctrl.sv
// request sequencer for the generational handle table
// depends on ght_pkg
`timescale 1ns / 1ps

module ght_ctrl
    import ght_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [10:0] {
        S_INIT   = 11'b000_0000_0001,
        S_IDLE   = 11'b000_0000_0010,
        S_DEC    = 11'b000_0000_0100,
        S_LK_CHK = 11'b000_0000_1000,
        S_AL_RD  = 11'b000_0001_0000,
        S_AL_CHK = 11'b000_0010_0000,
        S_AL_GRD = 11'b000_0100_0000,
        S_AL_GEN = 11'b000_1000_0000,
        S_CL_RD  = 11'b001_0000_0000,
        S_CL_WR  = 11'b010_0000_0000,
        S_CL_FIN = 11'b100_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_INIT: begin
                // clearing pass over the whole table
                o_cmd.wr_op = W_INIT;
                o_cmd.x_op  = X_INC;
                if (i_sts.idx_last) begin
                    o_cmd.hint_clr = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.cap  = 1'b1;
                    o_cmd.x_op = X_REQ;
                    n_state    = S_DEC;
                end
            end
            S_DEC: begin
                unique case (i_sts.action) inside
                    ACT_ALLOC: n_state = S_AL_RD;
                    ACT_LOOKUP, ACT_FREE: n_state = S_LK_CHK;
                    ACT_CLEAR: begin
                        o_cmd.x_op = X_ZERO;
                        n_state    = S_CL_RD;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_LK_CHK: begin
                if (i_sts.out_free) begin
                    o_cmd.out_sel = O_LOOKUP;
                    if (i_sts.hit && i_sts.action == ACT_FREE) begin
                        o_cmd.wr_op = W_FREE;
                    end
                    n_state = S_IDLE;
                end
            end
            S_AL_RD: begin
                o_cmd.rd_hint = 1'b1;
                n_state       = S_AL_CHK;
            end
            S_AL_CHK: begin
                o_cmd.rd_hint = 1'b1;
                if (i_sts.hint_full) begin
                    if (i_sts.out_free) begin
                        o_cmd.out_sel = O_FULL;
                        n_state       = S_IDLE;
                    end
                end else if (i_sts.row_free) begin
                    o_cmd.wr_op = W_ALLOC;
                    n_state     = S_AL_GRD;
                end else begin
                    o_cmd.hint_inc = 1'b1;
                    n_state        = S_AL_RD;
                end
            end
            S_AL_GRD: begin
                n_state = S_AL_GEN;
            end
            S_AL_GEN: begin
                if (i_sts.out_free) begin
                    o_cmd.out_sel = O_ALLOC;
                    n_state       = S_IDLE;
                end
            end
            S_CL_RD: begin
                n_state = S_CL_WR;
            end
            S_CL_WR: begin
                o_cmd.wr_op = W_CLR;
                o_cmd.x_op  = X_INC;
                n_state     = i_sts.idx_last ? S_CL_FIN : S_CL_RD;
            end
            S_CL_FIN: begin
                o_cmd.hint_clr = 1'b1;
                if (i_sts.out_free) begin
                    o_cmd.out_sel = O_CLEAR;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_INIT;
        endcase
    end

endmodule

### design/ght_dp.sv
// table memories, free-slot search, handle check and output register
// depends on ght_pkg
`timescale 1ns / 1ps

module ght_dp
    import ght_pkg::*;
#(
    parameter int SLOTS = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_handle_slot,
    input  logic [31:0] i_handle_generation,
    input  logic [63:0] i_payload,
    input  logic [15:0] i_stage_tag,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [31:0] o_out_slot,
    output logic [31:0] o_out_generation,
    output logic [63:0] o_out_payload,
    output logic [15:0] o_out_stage
);

    localparam int SIW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LROWS = (SLOTS + ROW_W - 1) / ROW_W;
    localparam int RIW   = (LROWS > 1) ? $clog2(LROWS) : 1;
    localparam int XW    = RIW + ROW_BW;
    localparam int HW    = RIW + 1;
    localparam int EW    = HW + ROW_BW;
    localparam logic [EW-1:0] SLOTS_E = EW'(SLOTS);
    localparam logic [XW-1:0] LAST_X  = XW'(SLOTS - 1);
    localparam logic [HW-1:0] FULL_H  = HW'(LROWS);

    logic [31:0]      gen_mem  [SLOTS];
    logic [ROW_W-1:0] live_mem [LROWS];
    logic [79:0]      obj_mem  [SLOTS];

    // request
    t_action     r_action;
    logic [31:0] r_hslot;
    logic [31:0] r_hgen;
    logic [63:0] r_pay;
    logic [15:0] r_stg;
    logic        r_in_range;

    logic [XW-1:0]    r_x;
    logic [HW-1:0]    r_hint;
    logic [31:0]      r_gen_q;
    logic [ROW_W-1:0] r_row_q;
    logic [79:0]      r_obj_q;

    // result
    logic        r_ov;
    t_status     r_status;
    logic [31:0] r_oslot;
    logic [31:0] r_ogen;
    logic [63:0] r_opay;
    logic [15:0] r_ostg;

    logic [RIW-1:0]    w_raddr;
    logic [RIW-1:0]    w_xrow;
    logic [SIW-1:0]    w_gaddr;
    logic [ROW_W-1:0]  w_masked;
    logic [ROW_BW-1:0] w_found_bit;
    logic [ROW_W-1:0]  w_found_1h;
    logic [ROW_W-1:0]  w_bit_1h;
    logic [XW-1:0]     w_x_found;
    logic              w_row_free;
    logic              w_bit_live;
    logic              w_hit;
    logic              w_idx_last;
    logic              w_row_end;
    logic              w_out_free;

    assign w_xrow  = r_x[XW-1:ROW_BW];
    assign w_raddr = i_cmd.rd_hint ? r_hint[RIW-1:0] : w_xrow;
    assign w_gaddr = r_x[SIW-1:0];

    // slots past the table count as taken
    always_comb begin
        for (int b = 0; b < ROW_W; b++) begin
            w_masked[b] = r_row_q[b] | ({r_hint, ROW_BW'(b)} >= SLOTS_E);
        end
    end

    // lowest free bit of the hint row
    always_comb begin
        w_found_bit = '0;
        for (int b = ROW_W - 1; b >= 0; b--) begin
            if (!w_masked[b]) begin
                w_found_bit = ROW_BW'(b);
            end
        end
    end

    assign w_row_free = ~&w_masked;
    assign w_found_1h = ROW_W'(1) << w_found_bit;
    assign w_bit_1h   = ROW_W'(1) << r_x[ROW_BW-1:0];
    assign w_x_found  = {r_hint[RIW-1:0], w_found_bit};
    assign w_bit_live = r_row_q[r_x[ROW_BW-1:0]];
    assign w_hit      = r_in_range && w_bit_live && (r_gen_q == r_hgen);
    assign w_idx_last = (r_x == LAST_X);
    assign w_row_end  = (r_x[ROW_BW-1:0] == ROW_BW'(ROW_W - 1)) || w_idx_last;
    assign w_out_free = !r_ov || i_ready;

    always_comb begin
        o_sts.action    = r_action;
        o_sts.out_free  = w_out_free;
        o_sts.hit       = w_hit;
        o_sts.row_free  = w_row_free;
        o_sts.hint_full = (r_hint == FULL_H);
        o_sts.idx_last  = w_idx_last;
    end

    // memories: registered reads every cycle, one write port each
    always_ff @(posedge i_clk) begin
        r_gen_q <= gen_mem[w_gaddr];
        r_row_q <= live_mem[w_raddr];
        r_obj_q <= obj_mem[w_gaddr];
        case (i_cmd.wr_op)
            W_INIT: begin
                gen_mem[w_gaddr] <= '0;
                live_mem[w_xrow] <= '0;
            end
            W_ALLOC: begin
                live_mem[r_hint[RIW-1:0]]  <= r_row_q | w_found_1h;
                obj_mem[w_x_found[SIW-1:0]] <= {r_pay, r_stg};
            end
            W_FREE: begin
                gen_mem[w_gaddr] <= r_gen_q + 32'd1;
                live_mem[w_xrow] <= r_row_q & ~w_bit_1h;
            end
            W_CLR: begin
                if (w_bit_live) begin
                    gen_mem[w_gaddr] <= r_gen_q + 32'd1;
                end
                if (w_row_end) begin
                    live_mem[w_xrow] <= '0;
                end
            end
            default: ;
        endcase
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_action   <= t_action'(i_action);
            r_hslot    <= i_handle_slot;
            r_hgen     <= i_handle_generation;
            r_pay      <= i_payload;
            r_stg      <= i_stage_tag;
            r_in_range <= (i_handle_slot != 32'd0) && (i_handle_slot <= 32'(SLOTS));
        end
    end

    // index and search hint
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x    <= '0;
            r_hint <= '0;
        end else begin
            if (i_cmd.wr_op == W_ALLOC) begin
                r_x <= w_x_found;
            end else begin
                case (i_cmd.x_op)
                    X_REQ:   r_x <= XW'(i_handle_slot - 32'd1);
                    X_ZERO:  r_x <= '0;
                    X_INC:   r_x <= r_x + XW'(1);
                    default: r_x <= r_x;
                endcase
            end
            if (i_cmd.hint_clr) begin
                r_hint <= '0;
            end else if (i_cmd.hint_inc) begin
                r_hint <= r_hint + HW'(1);
            end else if (i_cmd.wr_op == W_FREE && {1'b0, w_xrow} < r_hint) begin
                r_hint <= {1'b0, w_xrow};
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.out_sel != O_NONE) begin
            r_ov <= 1'b1;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.out_sel)
            O_LOOKUP: begin
                r_oslot <= r_hslot;
                if (w_hit) begin
                    r_status <= ST_OK;
                    r_ogen   <= r_gen_q;
                    r_opay   <= r_obj_q[79:16];
                    r_ostg   <= r_obj_q[15:0];
                end else begin
                    r_status <= ST_INVALID;
                    r_ogen   <= '0;
                    r_opay   <= '0;
                    r_ostg   <= '0;
                end
            end
            O_ALLOC: begin
                r_status <= ST_OK;
                r_oslot  <= 32'(r_x) + 32'd1;
                r_ogen   <= r_gen_q;
                r_opay   <= '0;
                r_ostg   <= '0;
            end
            O_FULL: begin
                r_status <= ST_FULL;
                r_oslot  <= '0;
                r_ogen   <= '0;
                r_opay   <= '0;
                r_ostg   <= '0;
            end
            O_CLEAR: begin
                r_status <= ST_OK;
                r_oslot  <= '0;
                r_ogen   <= '0;
                r_opay   <= '0;
                r_ostg   <= '0;
            end
            default: ;
        endcase
    end

    assign o_valid          = r_ov;
    assign o_status         = r_status;
    assign o_out_slot       = r_oslot;
    assign o_out_generation = r_ogen;
    assign o_out_payload    = r_opay;
    assign o_out_stage      = r_ostg;

endmodule

### design/ght_chk.sv
// port-level checks for the generational handle table, bound to the top level
// depends on ght_pkg and generational_handle_table_core
`timescale 1ns / 1ps

module ght_chk
    import ght_pkg::*;
#(
    parameter int SLOTS = 512
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [1:0]  o_status,
    input logic [31:0] o_out_slot,
    input logic [31:0] o_out_generation,
    input logic [63:0] o_out_payload,
    input logic [15:0] o_out_stage
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_out_slot)
            && $stable(o_out_generation) && $stable(o_out_payload)
            && $stable(o_out_stage))
        else $error("result beat changed while stalled");

    // one request in flight: ready drops after an accepted beat
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("request taken while another is in flight");

    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_FULL |-> o_out_slot == 32'd0
            && o_out_generation == 32'd0 && o_out_payload == 64'd0
            && o_out_stage == 16'd0)
        else $error("table full result carries data");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_INVALID |-> o_out_generation == 32'd0
            && o_out_payload == 64'd0 && o_out_stage == 16'd0)
        else $error("invalid handle result carries data");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_OK && o_out_slot != 32'd0
            |-> o_out_slot <= 32'(SLOTS))
        else $error("ok result names a slot past the table");

endmodule

bind generational_handle_table_core ght_chk #(
    .SLOTS (SLOTS)
) u_ght_chk (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_valid             (i_valid),
    .o_ready             (o_ready),
    .o_valid             (o_valid),
    .i_ready             (i_ready),
    .o_status            (o_status),
    .o_out_slot          (o_out_slot),
    .o_out_generation    (o_out_generation),
    .o_out_payload       (o_out_payload),
    .o_out_stage         (o_out_stage)
);
